// ===== rtl/utt_pkg.sv =====
// shared types and constants for the utilization token throttle
package utt_pkg;

  localparam int CFG_W       = 13;
  localparam int GRID_W      = 31;
  localparam int UTIL_W      = 10;
  localparam int LIMIT_W     = 7;
  localparam int TOKEN_W     = 48;
  localparam int SHARE_W     = 47;
  localparam int DIV_W       = 36;
  localparam int DVR_W       = 12;
  localparam int DIV_STEPS   = DIV_W / 2;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0]         RESET_SM_COUNT  = 8'd108;
  localparam logic [12:0]        RESET_THREADS   = 13'd2048;
  localparam logic [LIMIT_W-1:0] RESET_LIMIT     = 7'd100;
  localparam logic [LIMIT_W-1:0] UTIL_FULL       = 7'd100;
  localparam logic [LIMIT_W-1:0] GAP_MIN         = 7'd5;
  localparam logic [DVR_W-1:0]   SHARE_DIVISOR   = 12'd2560;

  typedef struct packed {
    logic              op;
    logic [GRID_W-1:0] grid_count;
    logic [UTIL_W-1:0] user_util;
  } in_item_t;

  typedef struct packed {
    logic                      granted;
    logic signed [TOKEN_W-1:0] tokens_now;
    logic [SHARE_W-1:0]        share_now;
    logic [SHARE_W-1:0]        pool_now;
  } out_item_t;

  typedef enum logic [1:0] {
    CFG_SM_COUNT        = 2'd0,
    CFG_THREADS_PER_SM  = 2'd1,
    CFG_UTIL_LIMIT      = 2'd2,
    CFG_THROTTLE_ENABLE = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0]         sm_count;
    logic [12:0]        threads_per_sm;
    logic [LIMIT_W-1:0] util_limit;
    logic               throttle_enable;
  } cfg_t;

  typedef enum logic [1:0] {
    KIND_LAUNCH_FREE,
    KIND_LAUNCH,
    KIND_TICK_IDLE,
    KIND_TICK
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [GRID_W-1:0]  grid;
    logic               user_ok;
    logic               below;
    logic               accel;
    logic [LIMIT_W-1:0] gap;
  } cmd_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RELOAD_MUL,
    ST_RELOAD_SET,
    ST_MUL_SQ,
    ST_MUL_THR,
    ST_MUL_GAP,
    ST_DIV_BASE,
    ST_DIV_ACC,
    ST_SHARE,
    ST_TOKENS,
    ST_FIN
  } back_state_t;

endpackage

// ===== rtl/utilization_token_throttle_core.sv =====
// Token-bucket launch throttle. Each input transaction gives exactly one result. A launch
// request passes the front stage and command queue and is decided in the back part when it
// is popped, and its result is then registered on the output. A utilization tick with the
// limit in range and a utilization of at most 100 runs the refill sequence: three multiply
// steps and then a 36-bit divide at two bits per cycle, repeated by the limit-plus-one
// divisor when the utilization gap is wide. The back part holds one transaction at a time
// while the front stage and a two-entry queue keep taking new ones until they fill. A write
// of sm_count or threads_per_sm reloads the pool size through the RELOAD_MUL and RELOAD_SET
// states once the back part is idle, ahead of any queued transaction.
module utilization_token_throttle_core #(
  parameter int POOL_FACTOR = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [utt_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  utt_pkg::in_item_t           in_item,
  output logic                        out_valid,
  input  logic                        out_stall,
  output utt_pkg::out_item_t          out_item
);
  import utt_pkg::*;

  cfg_t     cfg;
  cfg_idx_t idx;
  logic     cfg_reload;
  logic     push;
  cmd_t     push_cmd;
  logic     q_full;
  logic     q_empty;
  logic     pop;
  cmd_t     pop_cmd;
  div_req_t div_req;
  div_rsp_t div_rsp;

  assign idx        = cfg_idx_t'(cfg_index);
  assign cfg_reload = cfg_we && (idx == CFG_SM_COUNT || idx == CFG_THREADS_PER_SM);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sm_count        <= RESET_SM_COUNT;
      cfg.threads_per_sm  <= RESET_THREADS;
      cfg.util_limit      <= RESET_LIMIT;
      cfg.throttle_enable <= 1'b1;
    end else if (cfg_we) begin
      unique case (idx)
        CFG_SM_COUNT:        cfg.sm_count        <= cfg_data[7:0];
        CFG_THREADS_PER_SM:  cfg.threads_per_sm  <= cfg_data[12:0];
        CFG_UTIL_LIMIT:      cfg.util_limit      <= cfg_data[LIMIT_W-1:0];
        CFG_THROTTLE_ENABLE: cfg.throttle_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  utt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .push     (push),
    .push_cmd (push_cmd),
    .q_full   (q_full)
  );

  utt_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty)
  );

  utt_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  utt_back #(
    .POOL_FACTOR (POOL_FACTOR)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cfg_reload (cfg_reload),
    .cmd_valid  (!q_empty),
    .cmd        (pop_cmd),
    .pop        (pop),
    .div_req    (div_req),
    .div_rsp    (div_rsp),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

endmodule

// ===== rtl/utt_front.sv =====
// front stage: takes input transactions and classifies them into commands
module utt_front (
  input  logic              clk,
  input  logic              rst,
  input  utt_pkg::cfg_t     cfg,
  input  logic              in_valid,
  output logic              in_stall,
  input  utt_pkg::in_item_t in_item,
  output logic              push,
  output utt_pkg::cmd_t     push_cmd,
  input  logic              q_full
);
  import utt_pkg::*;

  logic               st_valid;
  cmd_t               st_cmd;
  cmd_t               cls;
  logic               accept;
  logic [LIMIT_W-1:0] user7;
  logic [LIMIT_W-1:0] diff;
  logic               bypass;
  logic               tick_on;

  assign in_stall = st_valid && q_full;
  assign accept   = in_valid && !in_stall;
  assign push     = st_valid && !q_full;
  assign push_cmd = st_cmd;

  assign user7   = in_item.user_util[LIMIT_W-1:0];
  assign bypass  = (cfg.util_limit == '0) || (cfg.util_limit >= UTIL_FULL)
                   || !cfg.throttle_enable;
  assign tick_on = (cfg.util_limit != '0) && (cfg.util_limit <= UTIL_FULL);

  always_comb begin
    diff = (cfg.util_limit > user7) ? (cfg.util_limit - user7) : (user7 - cfg.util_limit);
    cls.grid    = in_item.grid_count;
    cls.user_ok = in_item.user_util <= UTIL_W'(UTIL_FULL);
    cls.below   = in_item.user_util <= UTIL_W'(cfg.util_limit);
    cls.gap     = (diff < GAP_MIN) ? GAP_MIN : diff;
    cls.accel   = cls.gap > (cfg.util_limit >> 1);
    if (in_item.op) begin
      cls.kind = tick_on ? KIND_TICK : KIND_TICK_IDLE;
    end else begin
      cls.kind = bypass ? KIND_LAUNCH_FREE : KIND_LAUNCH;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (accept) begin
      st_valid <= 1'b1;
    end else if (push) begin
      st_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      st_cmd <= cls;
    end
  end

endmodule

// ===== rtl/utt_queue.sv =====
// short command queue between the front and back parts
module utt_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  utt_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output utt_pkg::cmd_t pop_cmd,
  output logic          empty
);
  import utt_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          mem [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = count == CW'(QUEUE_DEPTH);
  assign empty   = count == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_cmd = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ===== rtl/utt_divider.sv =====
// restoring divider, two quotient bits per cycle
module utt_divider (
  input  logic              clk,
  input  logic              rst,
  input  utt_pkg::div_req_t req,
  output utt_pkg::div_rsp_t rsp
);
  import utt_pkg::*;

  logic [DIV_CNT_W-1:0] cnt;
  logic [DVR_W-1:0]     rem;
  logic [DIV_W-1:0]     quo;
  logic [DVR_W-1:0]     dvr;
  logic                 done;
  logic [DVR_W-1:0]     rem_next;
  logic [DIV_W-1:0]     quo_next;

  always_comb begin
    logic [DVR_W:0] rs;
    logic           ge;
    rem_next = rem;
    quo_next = quo;
    for (int i = 0; i < 2; i++) begin
      rs       = {rem_next, quo_next[DIV_W-1]};
      ge       = rs >= {1'b0, dvr};
      quo_next = {quo_next[DIV_W-2:0], ge};
      rs       = ge ? (rs - {1'b0, dvr}) : rs;
      rem_next = rs[DVR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (req.start) begin
      cnt  <= DIV_CNT_W'(DIV_STEPS);
      done <= 1'b0;
    end else if (cnt != '0) begin
      cnt  <= cnt - 1'b1;
      done <= cnt == DIV_CNT_W'(1);
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
      dvr <= req.divisor;
    end else if (cnt != '0) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

// ===== rtl/utt_back.sv =====
// back part: token, share and pool state, refill sequencer and result register
module utt_back #(
  parameter int POOL_FACTOR = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  utt_pkg::cfg_t      cfg,
  input  logic               cfg_reload,
  input  logic               cmd_valid,
  input  utt_pkg::cmd_t      cmd,
  output logic               pop,
  output utt_pkg::div_req_t  div_req,
  input  utt_pkg::div_rsp_t  div_rsp,
  output logic               out_valid,
  input  logic               out_stall,
  output utt_pkg::out_item_t out_item
);
  import utt_pkg::*;

  localparam int FACTOR_W = $clog2(POOL_FACTOR + 1);
  localparam logic [SHARE_W-1:0] RESET_POOL =
    SHARE_W'(longint'(RESET_SM_COUNT) * longint'(RESET_THREADS) * longint'(POOL_FACTOR));
  localparam logic [FACTOR_W-1:0] FACTOR = FACTOR_W'(POOL_FACTOR);

  back_state_t state, state_next;

  logic signed [TOKEN_W-1:0] tokens;
  logic [SHARE_W-1:0]        share;
  logic [SHARE_W-1:0]        pool;
  logic                      reload_pend;
  logic                      granted;
  logic [LIMIT_W-1:0]        cur_gap;
  logic                      cur_below;
  logic                      cur_accel;
  logic [28:0]               mul_q;
  logic [DIV_W-1:0]          inc;
  logic                      out_free;
  logic                      out_load;

  logic [DIV_W-1:0]          base_prod;
  logic [DIV_W+LIMIT_W-1:0]  acc_prod;
  logic [20+FACTOR_W:0]      pool_raw;
  logic signed [TOKEN_W:0]   sub_t;
  logic signed [TOKEN_W:0]   floor_t;
  logic [TOKEN_W-1:0]        dbl_pool;
  logic [SHARE_W-1:0]        dbl_sat;
  logic [TOKEN_W-1:0]        share_sum;
  logic [SHARE_W-1:0]        inc_w;
  logic signed [TOKEN_W:0]   add_t;
  logic signed [TOKEN_W:0]   pool_t;

  assign out_free  = !out_valid || !out_stall;
  assign base_prod = mul_q * cur_gap;
  assign acc_prod  = div_rsp.quotient * cur_gap;
  assign pool_raw  = mul_q[20:0] * FACTOR;
  assign sub_t     = {tokens[TOKEN_W-1], tokens} - $signed({18'b0, cmd.grid});
  assign floor_t   = -$signed({2'b0, pool});
  assign dbl_pool  = {pool, 1'b0};
  assign dbl_sat   = dbl_pool[TOKEN_W-1] ? '1 : dbl_pool[SHARE_W-1:0];
  assign inc_w     = SHARE_W'(inc);
  assign share_sum = {1'b0, share} + {1'b0, inc_w};
  assign add_t     = {tokens[TOKEN_W-1], tokens} + $signed({2'b0, share});
  assign pool_t    = $signed({2'b0, pool});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next       = state;
    pop              = 1'b0;
    out_load         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = base_prod;
    div_req.divisor  = SHARE_DIVISOR;
    unique case (state)
      ST_IDLE: begin
        if (reload_pend) begin
          state_next = ST_RELOAD_MUL;
        end else if (cmd_valid) begin
          pop        = 1'b1;
          state_next = (cmd.kind == KIND_TICK && cmd.user_ok) ? ST_MUL_SQ : ST_FIN;
        end
      end
      ST_RELOAD_MUL: state_next = ST_RELOAD_SET;
      ST_RELOAD_SET: state_next = ST_IDLE;
      ST_MUL_SQ:     state_next = ST_MUL_THR;
      ST_MUL_THR:    state_next = ST_MUL_GAP;
      ST_MUL_GAP: begin
        div_req.start = 1'b1;
        state_next    = ST_DIV_BASE;
      end
      ST_DIV_BASE: begin
        if (div_rsp.done) begin
          if (cur_accel) begin
            // widened step: inc * gap * 2 / (limit + 1)
            div_req.start    = 1'b1;
            div_req.dividend = {acc_prod[DIV_W-2:0], 1'b0};
            div_req.divisor  = DVR_W'(cfg.util_limit) + DVR_W'(1);
            state_next       = ST_DIV_ACC;
          end else begin
            state_next = ST_SHARE;
          end
        end
      end
      ST_DIV_ACC: begin
        if (div_rsp.done) begin
          state_next = ST_SHARE;
        end
      end
      ST_SHARE:  state_next = ST_TOKENS;
      ST_TOKENS: state_next = ST_FIN;
      ST_FIN: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tokens      <= '0;
      share       <= '0;
      pool        <= RESET_POOL;
      reload_pend <= 1'b0;
    end else begin
      if (cfg_reload) begin
        reload_pend <= 1'b1;
      end else if (state == ST_IDLE && reload_pend) begin
        reload_pend <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (pop) begin
            if (cmd.kind == KIND_LAUNCH && !tokens[TOKEN_W-1]) begin
              tokens <= (sub_t < floor_t) ? floor_t[TOKEN_W-1:0] : sub_t[TOKEN_W-1:0];
            end
            // exhausted pool at full share: grow it
            if (cmd.kind == KIND_TICK && share == pool && tokens[TOKEN_W-1]) begin
              pool  <= dbl_sat;
              share <= dbl_sat;
            end
          end
        end
        ST_RELOAD_SET: pool <= SHARE_W'(pool_raw);
        ST_SHARE: begin
          if (cur_below) begin
            share <= (share_sum > {1'b0, pool}) ? pool : share_sum[SHARE_W-1:0];
          end else begin
            share <= (inc_w > share) ? '0 : share - inc_w;
          end
        end
        ST_TOKENS: begin
          tokens <= (add_t > pool_t) ? pool_t[TOKEN_W-1:0] : add_t[TOKEN_W-1:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      granted   <= (cmd.kind == KIND_LAUNCH_FREE)
                   || (cmd.kind == KIND_LAUNCH && !tokens[TOKEN_W-1]);
      cur_gap   <= cmd.gap;
      cur_below <= cmd.below;
      cur_accel <= cmd.accel;
    end
    unique case (state)
      ST_RELOAD_MUL: mul_q <= 29'(cfg.sm_count * cfg.threads_per_sm);
      ST_MUL_SQ:     mul_q <= 29'(cfg.sm_count * cfg.sm_count);
      ST_MUL_THR:    mul_q <= 29'(mul_q[15:0] * cfg.threads_per_sm);
      default: ;
    endcase
    if ((state == ST_DIV_BASE && !cur_accel) || state == ST_DIV_ACC) begin
      if (div_rsp.done) begin
        inc <= div_rsp.quotient;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_item.granted    <= granted;
      out_item.tokens_now <= tokens;
      out_item.share_now  <= share;
      out_item.pool_now   <= pool;
    end
  end

endmodule

// ===== rtl/utt_checker.sv =====
// port-level checks for the throttle core, bound to the top level
module utt_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input utt_pkg::out_item_t out_item
);

  // no result may be left over from before reset
  a_reset_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // the front stage is empty after reset, so input is never held off then
  a_reset_in: assert property (@(posedge clk) rst |=> !in_stall)
    else $error("input stalled right after reset");

  // a result held back keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  // an input that is not stalled stays free while no transaction is offered
  a_in_free: assert property (@(posedge clk) disable iff (rst)
    !in_valid && !in_stall |=> !in_stall)
    else $error("input stalled with no transaction offered");

endmodule

bind utilization_token_throttle_core utt_checker u_utt_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

// ===== sim/utilization_token_throttle_core_test.sv =====
// self-checking testbench for the utilization token throttle core
module utilization_token_throttle_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import utt_pkg::*;

  localparam int PERIOD       = 10;
  localparam int POOL_FACTOR  = 32;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 100;
  localparam int HOLD_PHASE   = 3;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 60;
  localparam longint LIMIT_CYCLES = 1_000_000;

  localparam logic OP_LAUNCH = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  localparam longint unsigned POOL_MAX   = (64'd1 << SHARE_W) - 1;
  localparam longint          RESET_POOL = 7077888;

  typedef struct packed {
    logic      pinned;
    out_item_t want;
  } cue_t;

  typedef struct {
    bit               is_write;
    cfg_idx_t         idx;
    logic [CFG_W-1:0] data;
    in_item_t         item;
    bit               pinned;
    out_item_t        want;
  } step_row_t;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             cfg_we    = 1'b0;
  logic [1:0]       cfg_index = '0;
  logic [CFG_W-1:0] cfg_data  = '0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  in_item_t         in_item   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_item_t        out_item;

  utilization_token_throttle_core #(.POOL_FACTOR(POOL_FACTOR)) u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  always #(PERIOD / 2) clk = ~clk;

  // bucket predictor state
  logic [7:0]         cur_sm;
  logic [12:0]        cur_threads;
  logic [LIMIT_W-1:0] cur_limit;
  logic               cur_enable;
  longint             bucket_tokens;
  longint unsigned    bucket_share;
  longint unsigned    bucket_pool;

  out_item_t due_results[$];
  cue_t      item_cues[$];
  step_row_t plan[$];
  int        errors   = 0;
  bit        calm     = 1'b0;
  bit        hold_req = 1'b0;

  function automatic void reload_bucket_pool();
    longint unsigned sm_w, thr_w, prod;
    sm_w  = cur_sm;
    thr_w = cur_threads;
    prod  = thr_w * sm_w * POOL_FACTOR;
    bucket_pool = (prod > POOL_MAX) ? POOL_MAX : prod;
  endfunction

  function automatic void reset_bucket();
    cur_sm        = RESET_SM_COUNT;
    cur_threads   = RESET_THREADS;
    cur_limit     = RESET_LIMIT;
    cur_enable    = 1'b1;
    bucket_tokens = 0;
    bucket_share  = 0;
    reload_bucket_pool();
  endfunction

  function automatic void apply_reg_write(cfg_idx_t idx, logic [CFG_W-1:0] data);
    case (idx)
      CFG_SM_COUNT: begin
        cur_sm = data[7:0];
        reload_bucket_pool();
      end
      CFG_THROTTLE_ENABLE: cur_enable = data[0];
      CFG_UTIL_LIMIT:      cur_limit = data[LIMIT_W-1:0];
      CFG_THREADS_PER_SM: begin
        cur_threads = data[12:0];
        reload_bucket_pool();
      end
      default: ;
    endcase
  endfunction

  function automatic out_item_t throttle_step(in_item_t it);
    out_item_t       res;
    longint unsigned lim, user, gap, inc, sm_w, thr_w;
    longint          sum, floor_v, grid_w, pool_s, share_s;
    res    = '0;
    lim    = cur_limit;
    user   = it.user_util;
    sm_w   = cur_sm;
    thr_w  = cur_threads;
    grid_w = it.grid_count;
    if (it.op == OP_LAUNCH) begin
      if (cur_limit == 0 || cur_limit >= UTIL_FULL || !cur_enable) begin
        res.granted = 1'b1;
      end else if (bucket_tokens >= 0) begin
        pool_s        = bucket_pool;
        floor_v       = -pool_s;
        sum           = bucket_tokens - grid_w;
        bucket_tokens = (sum < floor_v) ? floor_v : sum;
        res.granted   = 1'b1;
      end
    end else if (cur_limit >= 1 && cur_limit <= UTIL_FULL) begin
      // exhausted pool at full share grows before the refill
      if (bucket_share == bucket_pool && bucket_tokens < 0) begin
        bucket_pool  = (bucket_pool * 2 > POOL_MAX) ? POOL_MAX : bucket_pool * 2;
        bucket_share = bucket_pool;
      end
      if (user <= UTIL_FULL) begin
        gap = (lim > user) ? lim - user : user - lim;
        if (gap < GAP_MIN) gap = GAP_MIN;
        inc = sm_w * sm_w * thr_w * gap / SHARE_DIVISOR;
        if (gap > lim / 2) inc = inc * gap * 2 / (lim + 1);
        if (user <= lim) begin
          bucket_share = (bucket_share + inc > bucket_pool) ? bucket_pool : bucket_share + inc;
        end else begin
          bucket_share = (inc > bucket_share) ? 0 : bucket_share - inc;
        end
        pool_s        = bucket_pool;
        share_s       = bucket_share;
        sum           = bucket_tokens + share_s;
        bucket_tokens = (sum > pool_s) ? pool_s : sum;
      end
    end
    res.tokens_now = bucket_tokens[TOKEN_W-1:0];
    res.share_now  = bucket_share[SHARE_W-1:0];
    res.pool_now   = bucket_pool[SHARE_W-1:0];
    return res;
  endfunction

  function automatic void report_field(string field, longint exp_v, longint got_v);
    $display("%0t: %s expected %0d got %0d", $time, field, exp_v, got_v);
    errors++;
  endfunction

  // results are checked before the new transaction is predicted
  always @(posedge clk) begin : watch
    out_item_t want;
    cue_t      cue;
    out_item_t guess;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          $display("%0t: result with none expected, tokens_now %0d", $time,
                   out_item.tokens_now);
          errors++;
        end else begin
          want = due_results.pop_front();
          if (out_item.granted !== want.granted)
            report_field("granted", want.granted, out_item.granted);
          if (out_item.tokens_now !== want.tokens_now)
            report_field("tokens_now", want.tokens_now, out_item.tokens_now);
          if (out_item.share_now !== want.share_now)
            report_field("share_now", want.share_now, out_item.share_now);
          if (out_item.pool_now !== want.pool_now)
            report_field("pool_now", want.pool_now, out_item.pool_now);
        end
      end
      if (in_valid && !in_stall) begin
        cue   = item_cues.pop_front();
        guess = throttle_step(in_item);
        due_results.push_back(cue.pinned ? cue.want : guess);
      end
    end
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  function automatic step_row_t reg_row(cfg_idx_t idx, int unsigned value);
    step_row_t r;
    r.is_write = 1'b1;
    r.idx      = idx;
    r.data     = value;
    r.item     = '0;
    r.pinned   = 1'b0;
    r.want     = '0;
    return r;
  endfunction

  function automatic step_row_t item_row(logic op, int unsigned grid, int unsigned user);
    step_row_t r;
    r.is_write          = 1'b0;
    r.idx               = CFG_SM_COUNT;
    r.data              = '0;
    r.item.op           = op;
    r.item.grid_count   = grid;
    r.item.user_util    = user;
    r.pinned            = 1'b0;
    r.want              = '0;
    return r;
  endfunction

  function automatic step_row_t pin(step_row_t r, bit g, longint tok, longint shr, longint pl);
    r.pinned          = 1'b1;
    r.want.granted    = g;
    r.want.tokens_now = tok[TOKEN_W-1:0];
    r.want.share_now  = shr[SHARE_W-1:0];
    r.want.pool_now   = pl[SHARE_W-1:0];
    return r;
  endfunction

  function automatic logic [GRID_W-1:0] rand_grid();
    int unsigned span;
    span = $urandom_range(0, GRID_W);
    if (span == GRID_W) return '1;
    return $urandom & ((32'd1 << span) - 1);
  endfunction

  task automatic offer(in_item_t it, logic pinned, out_item_t want);
    cue_t cue;
    cue.pinned = pinned;
    cue.want   = want;
    item_cues.push_back(cue);
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic maybe_pause();
    if (!calm && !hold_req && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (due_results.size() != 0);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    apply_reg_write(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    #(LIMIT_CYCLES * PERIOD);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    in_item_t           it;
    int                 sent;
    int                 runs;
    int                 pick;
    logic [7:0]         sm;
    logic [12:0]        thr;
    logic [LIMIT_W-1:0] lim;
    logic               en;
    logic [CFG_W-1:0]   junk;

    reset_bucket();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed part: reset values, bypass, refusal, limits and pool growth
    plan.push_back(pin(item_row(OP_LAUNCH, 32'h7FFF_FFFF, 0), 1, 0, 0, RESET_POOL));
    plan.push_back(pin(item_row(OP_TICK, 0, 1023), 0, 0, 0, RESET_POOL));
    plan.push_back(pin(item_row(OP_TICK, 32'h7FFF_FFFF, 100), 0, 46656, 46656, RESET_POOL));
    plan.push_back(reg_row(CFG_UTIL_LIMIT, 50));
    plan.push_back(pin(item_row(OP_LAUNCH, 0, 0), 1, 46656, 46656, RESET_POOL));
    plan.push_back(pin(item_row(OP_LAUNCH, 32'h7FFF_FFFF, 1023), 1, -RESET_POOL, 46656,
                       RESET_POOL));
    plan.push_back(pin(item_row(OP_LAUNCH, 1, 0), 0, -RESET_POOL, 46656, RESET_POOL));
    plan.push_back(item_row(OP_TICK, 0, 0));
    plan.push_back(item_row(OP_TICK, 0, 101));
    plan.push_back(item_row(OP_TICK, 0, 100));
    plan.push_back(item_row(OP_TICK, 0, 52));
    plan.push_back(reg_row(CFG_UTIL_LIMIT, 1));
    plan.push_back(item_row(OP_TICK, 0, 0));
    plan.push_back(item_row(OP_TICK, 0, 1));
    plan.push_back(item_row(OP_TICK, 0, 2));
    plan.push_back(reg_row(CFG_THROTTLE_ENABLE, 0));
    plan.push_back(item_row(OP_LAUNCH, 32'h7FFF_FFFF, 0));
    plan.push_back(reg_row(CFG_THROTTLE_ENABLE, 1));
    plan.push_back(reg_row(CFG_UTIL_LIMIT, 0));
    plan.push_back(item_row(OP_LAUNCH, 5, 0));
    plan.push_back(item_row(OP_TICK, 0, 0));
    plan.push_back(reg_row(CFG_UTIL_LIMIT, 127));
    plan.push_back(item_row(OP_TICK, 0, 0));
    plan.push_back(item_row(OP_LAUNCH, 32'h7FFF_FFFF, 0));
    plan.push_back(reg_row(CFG_UTIL_LIMIT, 99));
    plan.push_back(reg_row(CFG_SM_COUNT, 0));
    plan.push_back(item_row(OP_TICK, 0, 50));
    plan.push_back(item_row(OP_LAUNCH, 32'h7FFF_FFFF, 0));
    plan.push_back(reg_row(CFG_SM_COUNT, 255));
    plan.push_back(reg_row(CFG_THREADS_PER_SM, 8191));
    plan.push_back(item_row(OP_TICK, 0, 0));
    plan.push_back(item_row(OP_TICK, 0, 0));
    plan.push_back(item_row(OP_LAUNCH, 32'h7FFF_FFFF, 0));
    plan.push_back(item_row(OP_TICK, 0, 1023));
    plan.push_back(item_row(OP_TICK, 0, 0));

    foreach (plan[i]) begin
      if (plan[i].is_write) begin
        drain_results();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        offer(plan[i].item, plan[i].pinned, plan[i].want);
        maybe_pause();
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      drain_results();
      case (phase)
        0: begin
          sm = 8'd255; thr = 13'h1FFF; lim = 99; en = 1'b1;
        end
        1: begin
          sm = 8'd1; thr = 13'd1; lim = 1; en = 1'b1;
        end
        2: begin
          sm = RESET_SM_COUNT; thr = 13'd4096; lim = UTIL_FULL; en = 1'b1;
        end
        default: begin
          if ($urandom_range(0, 3) == 0) sm = 8'd255;
          else sm = $urandom_range(1, 255);
          if ($urandom_range(0, 3) == 0) thr = 13'h1FFF;
          else thr = $urandom_range(1, 4096);
          case ($urandom_range(0, 7))
            0:       lim = 0;
            1:       lim = UTIL_FULL;
            2:       lim = $urandom_range(101, 127);
            default: lim = $urandom_range(1, 99);
          endcase
          en = ($urandom_range(0, 5) != 0);
        end
      endcase
      if (phase == HOLD_PHASE) begin
        lim = $urandom_range(1, 99);
        en  = 1'b1;
      end
      if (phase == PHASES - 1) calm = 1'b1;

      // spare bits above each register carry junk
      junk = $urandom;
      write_reg(CFG_SM_COUNT, {junk[12:8], sm});
      write_reg(CFG_THREADS_PER_SM, thr);
      junk = $urandom;
      write_reg(CFG_UTIL_LIMIT, {junk[12:LIMIT_W], lim});
      junk = $urandom;
      write_reg(CFG_THROTTLE_ENABLE, {junk[12:1], en});
      if (phase == HOLD_PHASE) hold_req = 1'b1;

      sent = 0;
      while (sent < PHASE_ITEMS) begin
        pick = $urandom_range(0, 9);
        runs = $urandom_range(1, 5);
        for (int k = 0; k < runs; k++) begin
          it.grid_count = $urandom;
          it.user_util  = $urandom;
          case (pick)
            0, 1, 2: begin
              // refill at or under the target
              it.op = OP_TICK;
              if (cur_limit >= UTIL_FULL) it.user_util = $urandom_range(0, UTIL_FULL);
              else it.user_util = $urandom_range(0, cur_limit);
            end
            3, 4: begin
              it.op         = OP_LAUNCH;
              it.grid_count = ($urandom_range(0, 2) == 0) ? '1 : rand_grid();
            end
            5: begin
              // over-range samples only let the pool grow
              it.op        = OP_TICK;
              it.user_util = $urandom_range(UTIL_FULL + 1, 1023);
            end
            6: begin
              it.op = OP_TICK;
              if (cur_limit < UTIL_FULL)
                it.user_util = $urandom_range(cur_limit + 1, UTIL_FULL);
              else
                it.user_util = $urandom_range(UTIL_FULL + 1, 1023);
            end
            7: begin
              it.op         = $urandom;
              it.grid_count = rand_grid();
              it.user_util  = $urandom_range(0, UTIL_FULL);
            end
            default: it.op = $urandom;
          endcase
          offer(it, 1'b0, '0);
          sent++;
          maybe_pause();
        end
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== utilization_token_throttle_core.f =====
rtl/utt_pkg.sv
rtl/utt_front.sv
rtl/utt_queue.sv
rtl/utt_divider.sv
rtl/utt_back.sv
rtl/utilization_token_throttle_core.sv
rtl/utt_checker.sv
sim/utilization_token_throttle_core_test.sv
